// ----- hdl/clwseq_pkg.sv -----
// shared types, codes and constants for the character lcd write sequencer
package clwseq_pkg;

  localparam int unsigned DIGITS = 5;
  localparam int unsigned IDX_W = $clog2(DIGITS);
  localparam int unsigned CNT_W = $clog2(DIGITS + 1);
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_NUMBER = 3'd3,
    CMD_CURSOR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FOUR_BIT  = 3'd0,
    REG_FUNC_SET  = 3'd1,
    REG_DISP_MODE = 3'd2,
    REG_CLEAR     = 3'd3,
    REG_ENTRY     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam logic [7:0] RST_FUNC_SET  = 8'h28;
  localparam logic [7:0] RST_DISP_MODE = 8'h0C;
  localparam logic [7:0] RST_CLEAR     = 8'h01;
  localparam logic [7:0] RST_ENTRY     = 8'h06;

  localparam logic [7:0] CMD_HOME_4BIT = 8'h02;
  localparam logic [7:0] ROW0_BASE     = 8'h80;
  localparam logic [7:0] ROW1_BASE     = 8'hC0;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;

  localparam logic [4:0] WAIT_POWER_UP = 5'd30;
  localparam logic [4:0] WAIT_DISP     = 5'd1;
  localparam logic [4:0] WAIT_CLEAR    = 5'd1;
  localparam logic [4:0] WAIT_ENTRY    = 5'd2;
  localparam logic [4:0] WAIT_NONE     = 5'd0;

  // place value of digit position, most significant first
  function automatic logic [13:0] pow10(input idx_t pos);
    logic [13:0] v;
    v = 14'd1;
    unique case (pos)
      3'd0: v = 14'd10000;
      3'd1: v = 14'd1000;
      3'd2: v = 14'd100;
      3'd3: v = 14'd10;
      3'd4: v = 14'd1;
      default: v = 14'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/char_lcd_write_sequencer_unit.sv -----
// character lcd write sequencer: requests in, enable strobes out, apb config
// sequence: a request is registered into the byte buffer, strobes into the output register;
//   a decimal number is first converted by a shared compare-and-subtract unit, one step
//   per subtract and one per digit; a new request is taken only once the last strobe of the
//   previous one is loaded in the output register
// reset: synchronous active-low rst_n restores the config registers to their
//   defaults and empties the sequencer and output register
module char_lcd_write_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_command,
  input  logic [7:0]                        in_byte_value,
  input  logic [15:0]                       in_number,
  input  logic [5:0]                        in_column,
  input  logic                              in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_bus_value,
  output logic                              out_register_select,
  output logic [4:0]                        out_pre_wait_ms,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clwseq_pkg::ADDR_W-1:0]     paddr,
  input  logic [clwseq_pkg::DATA_W-1:0]     pwdata,
  output logic [clwseq_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  logic                      four_bit_r;
  logic [7:0]                func_set_r;
  logic [7:0]                disp_mode_r;
  logic [7:0]                clear_r;
  logic [7:0]                entry_r;
  logic                      cfg_wr;
  clwseq_pkg::reg_idx_t      cfg_idx;

  clwseq_pkg::state_t        state_r, state_nxt;
  logic [7:0]                bytes_r [clwseq_pkg::DIGITS];
  logic [7:0]                bytes_nxt [clwseq_pkg::DIGITS];
  logic [4:0]                waits_r [clwseq_pkg::DIGITS];
  logic [4:0]                waits_nxt [clwseq_pkg::DIGITS];
  clwseq_pkg::cnt_t          cnt_r, cnt_nxt;
  clwseq_pkg::idx_t          idx_r, idx_nxt;
  logic                      half_r, half_nxt;
  logic                      rs_r, rs_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [3:0]                digit_r, digit_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_bus_r, out_bus_nxt;
  logic                      out_rs_r, out_rs_nxt;
  logic [4:0]                out_wait_r, out_wait_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      in_xfer;
  logic                      out_free;
  logic [15:0]               place;
  logic                      ge;
  logic [7:0]                cur_byte;
  logic                      is_last;
  logic [7:0]                cursor_addr;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = clwseq_pkg::reg_idx_t'(paddr[clwseq_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r  <= 1'b1;
      func_set_r  <= clwseq_pkg::RST_FUNC_SET;
      disp_mode_r <= clwseq_pkg::RST_DISP_MODE;
      clear_r     <= clwseq_pkg::RST_CLEAR;
      entry_r     <= clwseq_pkg::RST_ENTRY;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        clwseq_pkg::REG_FOUR_BIT:  four_bit_r  <= pwdata[0];
        clwseq_pkg::REG_FUNC_SET:  func_set_r  <= pwdata[7:0];
        clwseq_pkg::REG_DISP_MODE: disp_mode_r <= pwdata[7:0];
        clwseq_pkg::REG_CLEAR:     clear_r     <= pwdata[7:0];
        clwseq_pkg::REG_ENTRY:     entry_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      clwseq_pkg::REG_FOUR_BIT:  prdata = {{(clwseq_pkg::DATA_W-1){1'b0}}, four_bit_r};
      clwseq_pkg::REG_FUNC_SET:  prdata = {{(clwseq_pkg::DATA_W-8){1'b0}}, func_set_r};
      clwseq_pkg::REG_DISP_MODE: prdata = {{(clwseq_pkg::DATA_W-8){1'b0}}, disp_mode_r};
      clwseq_pkg::REG_CLEAR:     prdata = {{(clwseq_pkg::DATA_W-8){1'b0}}, clear_r};
      clwseq_pkg::REG_ENTRY:     prdata = {{(clwseq_pkg::DATA_W-8){1'b0}}, entry_r};
      default:                   prdata = '0;
    endcase
  end

  // request side
  assign in_stall    = (state_r != clwseq_pkg::ST_IDLE);
  assign in_xfer     = in_valid & ~in_stall;
  assign out_free    = ~out_valid_r | ~out_stall;
  assign cursor_addr = (in_row ? clwseq_pkg::ROW1_BASE : clwseq_pkg::ROW0_BASE)
                       + {2'b00, in_column};

  // shared compare-and-subtract unit
  assign place = {2'b00, clwseq_pkg::pow10(idx_r)};
  assign ge    = (rem_r >= place);

  assign cur_byte = bytes_r[idx_r];
  assign is_last  = (idx_r == clwseq_pkg::idx_t'(cnt_r - clwseq_pkg::cnt_t'(1)))
                    & (~four_bit_r | half_r);

  always_comb begin
    state_nxt     = state_r;
    bytes_nxt     = bytes_r;
    waits_nxt     = waits_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    half_nxt      = half_r;
    rs_nxt        = rs_r;
    rem_nxt       = rem_r;
    digit_nxt     = digit_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_bus_nxt   = out_bus_r;
    out_rs_nxt    = out_rs_r;
    out_wait_nxt  = out_wait_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      clwseq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          half_nxt  = 1'b0;
          rs_nxt    = 1'b0;
          cnt_nxt   = clwseq_pkg::cnt_t'(1);
          state_nxt = clwseq_pkg::ST_EMIT;
          for (int i = 0; i < clwseq_pkg::DIGITS; i++) begin
            waits_nxt[i] = clwseq_pkg::WAIT_NONE;
          end
          unique case (in_command)
            clwseq_pkg::CMD_INIT: begin
              if (four_bit_r) begin
                bytes_nxt[0] = clwseq_pkg::CMD_HOME_4BIT;
                bytes_nxt[1] = func_set_r;
                bytes_nxt[2] = disp_mode_r;
                bytes_nxt[3] = clear_r;
                bytes_nxt[4] = entry_r;
                waits_nxt[0] = clwseq_pkg::WAIT_POWER_UP;
                waits_nxt[2] = clwseq_pkg::WAIT_DISP;
                waits_nxt[3] = clwseq_pkg::WAIT_CLEAR;
                waits_nxt[4] = clwseq_pkg::WAIT_ENTRY;
                cnt_nxt      = clwseq_pkg::cnt_t'(5);
              end else begin
                bytes_nxt[0] = func_set_r;
                bytes_nxt[1] = disp_mode_r;
                bytes_nxt[2] = clear_r;
                bytes_nxt[3] = entry_r;
                waits_nxt[0] = clwseq_pkg::WAIT_POWER_UP;
                waits_nxt[1] = clwseq_pkg::WAIT_DISP;
                waits_nxt[2] = clwseq_pkg::WAIT_CLEAR;
                waits_nxt[3] = clwseq_pkg::WAIT_ENTRY;
                cnt_nxt      = clwseq_pkg::cnt_t'(4);
              end
            end
            clwseq_pkg::CMD_BYTE: begin
              bytes_nxt[0] = in_byte_value;
            end
            clwseq_pkg::CMD_CHAR: begin
              bytes_nxt[0] = in_byte_value;
              rs_nxt       = 1'b1;
            end
            clwseq_pkg::CMD_NUMBER: begin
              rem_nxt   = in_number;
              digit_nxt = '0;
              rs_nxt    = 1'b1;
              cnt_nxt   = clwseq_pkg::cnt_t'(clwseq_pkg::DIGITS);
              state_nxt = clwseq_pkg::ST_CONV;
            end
            clwseq_pkg::CMD_CURSOR: begin
              bytes_nxt[0] = cursor_addr;
            end
            default: begin
              state_nxt = clwseq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      clwseq_pkg::ST_CONV: begin
        if (ge) begin
          rem_nxt   = rem_r - place;
          digit_nxt = digit_r + 4'd1;
        end else begin
          bytes_nxt[idx_r] = clwseq_pkg::ASCII_ZERO + {4'h0, digit_r};
          digit_nxt        = '0;
          if (idx_r == clwseq_pkg::idx_t'(clwseq_pkg::DIGITS - 1)) begin
            idx_nxt   = '0;
            state_nxt = clwseq_pkg::ST_EMIT;
          end else begin
            idx_nxt = idx_r + clwseq_pkg::idx_t'(1);
          end
        end
      end
      clwseq_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rs_nxt    = rs_r;
          out_last_nxt  = is_last;
          out_wait_nxt  = half_r ? clwseq_pkg::WAIT_NONE : waits_r[idx_r];
          if (!four_bit_r) begin
            out_bus_nxt = cur_byte;
          end else if (half_r) begin
            out_bus_nxt = {cur_byte[3:0], 4'h0};
          end else begin
            out_bus_nxt = {cur_byte[7:4], 4'h0};
          end
          if (four_bit_r && !half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            idx_nxt  = idx_r + clwseq_pkg::idx_t'(1);
          end
          if (is_last) begin
            state_nxt = clwseq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = clwseq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clwseq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      half_r      <= 1'b0;
      cnt_r       <= clwseq_pkg::cnt_t'(1);
      digit_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      half_r      <= half_nxt;
      cnt_r       <= cnt_nxt;
      digit_r     <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    waits_r    <= waits_nxt;
    rs_r       <= rs_nxt;
    rem_r      <= rem_nxt;
    out_bus_r  <= out_bus_nxt;
    out_rs_r   <= out_rs_nxt;
    out_wait_r <= out_wait_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_bus_value       = out_bus_r;
  assign out_register_select = out_rs_r;
  assign out_pre_wait_ms     = out_wait_r;
  assign out_last            = out_last_r;

  // checks
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clwseq_pkg::ST_CONV) |-> (digit_r < 4'd10))
    else $error("digit count out of range");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clwseq_pkg::ST_EMIT) |-> ({1'b0, idx_r} < {1'b0, cnt_r}))
    else $error("strobe index past byte count");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clwseq_pkg::ST_EMIT && out_valid_r && out_stall)
      |=> ($stable(idx_r) && $stable(half_r)))
    else $error("sequencer advanced while output stalled");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clwseq_pkg::ST_EMIT && out_free && is_last)
      |=> (state_r == clwseq_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("final strobe did not end the request");

endmodule

// ----- bench/clwseq_strobe_checker.sv -----
// lcd strobe checker: mirrors the config registers, expands each request into strobes, compares
module clwseq_strobe_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [2:0]                    in_command,
  input  logic [7:0]                    in_byte_value,
  input  logic [15:0]                   in_number,
  input  logic [5:0]                    in_column,
  input  logic                          in_row,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_bus_value,
  input  logic                          out_register_select,
  input  logic [4:0]                    out_pre_wait_ms,
  input  logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clwseq_pkg::ADDR_W-1:0] paddr,
  input  logic [clwseq_pkg::DATA_W-1:0] pwdata,
  input  logic                          pready,
  output int                            mismatch_count,
  output int                            strobes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] bus;
    logic       rs;
    logic [4:0] wait_ms;
    logic       last;
  } strobe_t;

  logic       four_bit;
  logic [7:0] func_code;
  logic [7:0] disp_code;
  logic [7:0] clr_code;
  logic [7:0] entry_code;

  strobe_t burst[$];
  strobe_t pending_strobes[$];
  strobe_t want;

  initial begin
    mismatch_count = 0;
    strobes_due = 0;
  end

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic rs, input logic [4:0] w);
    if (four_bit) begin
      burst.push_back({b[7:4], 4'h0, rs, w, 1'b0});
      burst.push_back({b[3:0], 4'h0, rs, clwseq_pkg::WAIT_NONE, 1'b0});
    end else begin
      burst.push_back({b, rs, w, 1'b0});
    end
  endfunction

  function automatic void expand_request(input logic [2:0] cmd, input logic [7:0] b,
                                         input logic [15:0] num, input logic [5:0] col,
                                         input logic r);
    logic [7:0] digit_chars [clwseq_pkg::DIGITS];
    int unsigned n;
    strobe_t tail;
    burst.delete();
    n = num;
    case (cmd)
      clwseq_pkg::CMD_INIT: begin
        if (four_bit) begin
          add_byte(clwseq_pkg::CMD_HOME_4BIT, 1'b0, clwseq_pkg::WAIT_POWER_UP);
          add_byte(func_code, 1'b0, clwseq_pkg::WAIT_NONE);
        end else begin
          add_byte(func_code, 1'b0, clwseq_pkg::WAIT_POWER_UP);
        end
        add_byte(disp_code, 1'b0, clwseq_pkg::WAIT_DISP);
        add_byte(clr_code, 1'b0, clwseq_pkg::WAIT_CLEAR);
        add_byte(entry_code, 1'b0, clwseq_pkg::WAIT_ENTRY);
      end
      clwseq_pkg::CMD_BYTE: add_byte(b, 1'b0, clwseq_pkg::WAIT_NONE);
      clwseq_pkg::CMD_CHAR: add_byte(b, 1'b1, clwseq_pkg::WAIT_NONE);
      clwseq_pkg::CMD_NUMBER: begin
        for (int i = clwseq_pkg::DIGITS - 1; i >= 0; i--) begin
          digit_chars[i] = clwseq_pkg::ASCII_ZERO + 8'(n % 10);
          n = n / 10;
        end
        for (int i = 0; i < clwseq_pkg::DIGITS; i++)
          add_byte(digit_chars[i], 1'b1, clwseq_pkg::WAIT_NONE);
      end
      clwseq_pkg::CMD_CURSOR:
        add_byte((r ? clwseq_pkg::ROW1_BASE : clwseq_pkg::ROW0_BASE) + {2'b00, col},
                 1'b0, clwseq_pkg::WAIT_NONE);
      default: ;
    endcase
    if (burst.size() > 0) begin
      tail = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) pending_strobes.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      four_bit   <= 1'b1;
      func_code  <= clwseq_pkg::RST_FUNC_SET;
      disp_code  <= clwseq_pkg::RST_DISP_MODE;
      clr_code   <= clwseq_pkg::RST_CLEAR;
      entry_code <= clwseq_pkg::RST_ENTRY;
      pending_strobes.delete();
      strobes_due = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_strobes.size() == 0) begin
          report($sformatf("unexpected strobe bus %02h", out_bus_value));
        end else begin
          want = pending_strobes.pop_front();
          if (out_bus_value !== want.bus)
            report($sformatf("bus_value %02h, want %02h", out_bus_value, want.bus));
          if (out_register_select !== want.rs)
            report($sformatf("register_select %b, want %b", out_register_select, want.rs));
          if (out_pre_wait_ms !== want.wait_ms)
            report($sformatf("pre_wait_ms %0d, want %0d", out_pre_wait_ms, want.wait_ms));
          if (out_last !== want.last)
            report($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      if (in_valid && !in_stall)
        expand_request(in_command, in_byte_value, in_number, in_column, in_row);
      if (psel && penable && pwrite && pready) begin
        case (clwseq_pkg::reg_idx_t'(paddr[clwseq_pkg::ADDR_W-1:2]))
          clwseq_pkg::REG_FOUR_BIT:  four_bit   <= pwdata[0];
          clwseq_pkg::REG_FUNC_SET:  func_code  <= pwdata[7:0];
          clwseq_pkg::REG_DISP_MODE: disp_code  <= pwdata[7:0];
          clwseq_pkg::REG_CLEAR:     clr_code   <= pwdata[7:0];
          clwseq_pkg::REG_ENTRY:     entry_code <= pwdata[7:0];
          default: ;
        endcase
      end
      strobes_due = pending_strobes.size();
    end
  end

endmodule

// ----- bench/tb_char_lcd_write_sequencer_unit.sv -----
// top-level bench for the lcd write sequencer: clock, reset, requests, config writes, verdict
module tb_char_lcd_write_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 60;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [2:0]                    in_command;
  logic [7:0]                    in_byte_value;
  logic [15:0]                   in_number;
  logic [5:0]                    in_column;
  logic                          in_row;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_bus_value;
  logic                          out_register_select;
  logic [4:0]                    out_pre_wait_ms;
  logic                          out_last;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [clwseq_pkg::ADDR_W-1:0] paddr;
  logic [clwseq_pkg::DATA_W-1:0] pwdata;
  logic [clwseq_pkg::DATA_W-1:0] prdata;
  logic                          pready;

  int mismatch_count;
  int strobes_due;
  int cycle_count = 0;
  int requests_sent;
  bit send_calm = 1'b0;

  char_lcd_write_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_byte_value(in_byte_value), .in_number(in_number), .in_column(in_column),
    .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_bus_value(out_bus_value),
    .out_register_select(out_register_select), .out_pre_wait_ms(out_pre_wait_ms),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  clwseq_strobe_checker strobe_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_byte_value(in_byte_value), .in_number(in_number), .in_column(in_column),
    .in_row(in_row),
    .out_valid(out_valid), .out_stall(out_stall), .out_bus_value(out_bus_value),
    .out_register_select(out_register_select), .out_pre_wait_ms(out_pre_wait_ms),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .mismatch_count(mismatch_count), .strobes_due(strobes_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall per strobe transfer, with calm stretches
  initial begin
    int stall_left;
    bit calm;
    out_stall <= 1'b0;
    stall_left = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 15) == 0) calm = !calm;
        stall_left = calm ? 0 : $urandom_range(0, 18);
      end
      @(negedge clk);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic write_reg(input clwseq_pkg::reg_idx_t idx,
                           input logic [clwseq_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic fb, input logic [7:0] f, input logic [7:0] d,
                                input logic [7:0] c, input logic [7:0] e);
    write_reg(clwseq_pkg::REG_FOUR_BIT, {31'd0, fb});
    write_reg(clwseq_pkg::REG_FUNC_SET, {24'd0, f});
    write_reg(clwseq_pkg::REG_DISP_MODE, {24'd0, d});
    write_reg(clwseq_pkg::REG_CLEAR, {24'd0, c});
    write_reg(clwseq_pkg::REG_ENTRY, {24'd0, e});
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] b,
                              input logic [15:0] num, input logic [5:0] col, input logic r);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command    <= cmd;
    in_byte_value <= b;
    in_number     <= num;
    in_column     <= col;
    in_row        <= r;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd <= clwseq_pkg::CMD_CURSOR) requests_sent++;
  endtask

  task automatic send_random_item();
    logic [2:0] cmd;
    logic [15:0] num;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) cmd = clwseq_pkg::CMD_INIT;
    else if (pick < 28) cmd = clwseq_pkg::CMD_BYTE;
    else if (pick < 48) cmd = clwseq_pkg::CMD_CHAR;
    else if (pick < 72) cmd = clwseq_pkg::CMD_NUMBER;
    else if (pick < 92) cmd = clwseq_pkg::CMD_CURSOR;
    else cmd = 3'($urandom_range(int'(clwseq_pkg::CMD_CURSOR) + 1, 7));
    num = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 99)) : 16'($urandom);
    send_request(cmd, 8'($urandom), num, 6'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (strobes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int target;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= clwseq_pkg::CMD_INIT;
    in_byte_value <= 8'h00;
    in_number     <= 16'h0000;
    in_column     <= 6'd0;
    in_row        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    requests_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, four-bit transfers
    send_request(clwseq_pkg::CMD_INIT, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_BYTE, 8'h00, 16'hFFFF, 6'h3F, 1'b1);
    send_request(clwseq_pkg::CMD_BYTE, 8'hFF, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CHAR, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CHAR, 8'hFF, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CHAR, 8'h5A, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_NUMBER, 8'hFF, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_NUMBER, 8'h00, 16'd65535, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_NUMBER, 8'h00, 16'd10009, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'd39, 1'b1);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'h3F, 1'b0);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'h3F, 1'b1);
    for (int k = int'(clwseq_pkg::CMD_CURSOR) + 1; k < 8; k++)
      send_request(3'(k), 8'hFF, 16'hFFFF, 6'h3F, 1'b1);
    drain();

    // eight-bit transfers, init codes all ones
    write_settings(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(clwseq_pkg::CMD_INIT, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_BYTE, 8'h3C, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CHAR, 8'hC3, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_NUMBER, 8'h00, 16'd65535, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_NUMBER, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'h3F, 1'b1);
    drain();

    // four-bit transfers, init codes all zeros
    write_settings(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(clwseq_pkg::CMD_INIT, 8'h00, 16'd0, 6'd0, 1'b0);
    send_request(clwseq_pkg::CMD_CURSOR, 8'h00, 16'd0, 6'd39, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_settings(1'(p), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      target = requests_sent + RANDOM_ITEMS / PHASES;
      while (requests_sent < target) send_random_item();
      drain();
    end

    if (mismatch_count == 0 && strobes_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
